// ===== hdl/handle_allocator_with_reuse_assert.svh =====
// Assertion macros used by the allocator's back end.
`ifndef HANDLE_ALLOCATOR_WITH_REUSE_ASSERT_SVH
`define HANDLE_ALLOCATOR_WITH_REUSE_ASSERT_SVH

`define HAL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define HAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hal_pkg.sv =====
`default_nettype none
package hal_pkg;

  localparam int HANDLE_COUNT = 1024;
  localparam int DATA_WIDTH   = 32;
  localparam int HANDLE_W     = 10;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = $clog2(HANDLE_COUNT);
  localparam int CNT_W        = $clog2(HANDLE_COUNT + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_GET   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ALLOC,
    OP_FREE,
    OP_GET
  } op_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [HANDLE_W-1:0] handle_in;
    logic [WORD_W-1:0]   data_in;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [WORD_W-1:0]   data_out;
    logic [1:0]          status;
  } res_t;

  typedef struct packed {
    op_e                   op;
    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } qhead_t;

endpackage
`default_nettype wire

// ===== hdl/hal_front.sv =====
`default_nettype none
module hal_front import hal_pkg::*; (
  input  wire logic   start,
  input  wire cmd_t   cmd_i,
  input  wire logic   full_i,
  input  wire logic   clearing_i,
  output logic        busy,
  output logic        push_o,
  output entry_t      entry_o
);

  always_comb begin
    busy             = full_i | clearing_i;
    push_o           = start & ~busy;
    entry_o.in_range = CNT_W'(cmd_i.handle_in) < CNT_W'(HANDLE_COUNT);
    entry_o.idx      = cmd_i.handle_in[IDX_W-1:0];
    entry_o.data     = cmd_i.data_in[DATA_WIDTH-1:0];
    unique case (cmd_i.command)
      CMD_ALLOC: entry_o.op = OP_ALLOC;
      CMD_FREE:  entry_o.op = OP_FREE;
      CMD_GET:   entry_o.op = OP_GET;
      default:   entry_o.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/hal_queue.sv =====
`default_nettype none
module hal_queue import hal_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output logic        full_o,
  output qhead_t      head_o
);

  entry_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  always_comb begin
    full_o        = count_q == QCNT_W'(QUEUE_DEPTH);
    head_o.valid  = count_q != '0;
    head_o.head   = slot_q[rd_ptr_q];
    wr_ptr_d      = wr_ptr_q;
    rd_ptr_d      = rd_ptr_q;
    count_d       = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hal_back.sv =====
`default_nettype none
`include "handle_allocator_with_reuse_assert.svh"
module hal_back import hal_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire qhead_t head_i,
  output logic        pop_o,
  output logic        clearing_o,
  output logic        done_o,
  output res_t        result_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                state_q;
  logic [IDX_W-1:0]      clr_idx_q;
  logic [CNT_W-1:0]      free_count_q, free_count_d;
  logic [CNT_W-1:0]      fresh_q, fresh_d;
  entry_t                cur_q;
  logic                  used_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic [IDX_W-1:0]      stack_rd_q;
  logic                  done_q;
  res_t                  res_q, res_d;

  logic                  in_use_mem [HANDLE_COUNT];
  logic [DATA_WIDTH-1:0] data_mem   [HANDLE_COUNT];
  logic [IDX_W-1:0]      stack_mem  [HANDLE_COUNT];

  logic                  used_we, used_wdata, used_we_x;
  logic [IDX_W-1:0]      used_waddr, used_waddr_x;
  logic                  data_we, stack_we;
  logic [IDX_W-1:0]      got;
  logic                  live;

  assign pop_o      = (state_q == S_IDLE) && head_i.valid;
  assign clearing_o = state_q == S_CLEAR;
  assign done_o     = done_q;
  assign result_o   = res_q;

  always_comb begin
    live         = cur_q.in_range & used_rd_q;
    res_d        = '0;
    free_count_d = free_count_q;
    fresh_d      = fresh_q;
    got          = stack_rd_q;
    used_we_x    = 1'b0;
    used_waddr_x = cur_q.idx;
    used_wdata   = 1'b0;
    data_we      = 1'b0;
    stack_we     = 1'b0;
    case (cur_q.op)
      OP_ALLOC: begin
        if (free_count_q != '0) begin
          got          = stack_rd_q;
          free_count_d = free_count_q - 1'b1;
        end else if (fresh_q < CNT_W'(HANDLE_COUNT)) begin
          got     = fresh_q[IDX_W-1:0];
          fresh_d = fresh_q + 1'b1;
        end
        if (free_count_q != '0 || fresh_q < CNT_W'(HANDLE_COUNT)) begin
          used_we_x        = 1'b1;
          used_waddr_x     = got;
          used_wdata       = 1'b1;
          data_we          = 1'b1;
          res_d.handle_out = HANDLE_W'(got);
        end else begin
          res_d.status = ST_EMPTY;
        end
      end
      OP_FREE: begin
        if (live && free_count_q < CNT_W'(HANDLE_COUNT)) begin
          used_we_x    = 1'b1;
          stack_we     = 1'b1;
          free_count_d = free_count_q + 1'b1;
        end else begin
          res_d.status = ST_UNKNOWN;
        end
      end
      OP_GET: begin
        if (live) begin
          res_d.data_out = WORD_W'(data_rd_q);
        end else begin
          res_d.status = ST_UNKNOWN;
        end
      end
      default: ;
    endcase
    if (state_q == S_CLEAR) begin
      used_we    = 1'b1;
      used_waddr = clr_idx_q;
      used_wdata = 1'b0;
    end else begin
      used_we    = (state_q == S_EXEC) && used_we_x;
      used_waddr = used_waddr_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      free_count_q <= '0;
      fresh_q      <= '0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == IDX_W'(HANDLE_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_i.valid) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          free_count_q <= free_count_d;
          fresh_q      <= fresh_d;
          res_q        <= res_d;
          done_q       <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q      <= head_i.head;
      used_rd_q  <= in_use_mem[head_i.head.idx];
      data_rd_q  <= data_mem[head_i.head.idx];
      stack_rd_q <= stack_mem[free_count_q[IDX_W-1:0] - 1'b1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      in_use_mem[used_waddr] <= used_wdata;
    end
    if ((state_q == S_EXEC) && data_we) begin
      data_mem[got] <= cur_q.data;
    end
    if ((state_q == S_EXEC) && stack_we) begin
      stack_mem[free_count_q[IDX_W-1:0]] <= cur_q.idx;
    end
  end

  `HAL_ASSERT_SAME(a_count_bound, 1'b1, free_count_q <= fresh_q, "free count above issued")
  `HAL_ASSERT_SAME(a_fresh_bound, 1'b1, fresh_q <= CNT_W'(HANDLE_COUNT), "fresh counter overflow")
  `HAL_ASSERT_NEXT(a_exec_done, state_q == S_EXEC, done_q, "result strobe missing")
  `HAL_ASSERT_SAME(a_no_pop_clear, state_q == S_CLEAR, !pop_o && !done_q, "work during clear")

endmodule
`default_nettype wire

// ===== hdl/handle_allocator_with_reuse.sv =====
// With the back end idle, an accepted command is queued, read in the idle state, then updated in the exec state.
// The back end takes a new command only once the read then update pass of the last one is done.
// A two entry queue lets busy stay low for up to two commands while the back end works.
// After reset the in-use map is cleared, one entry a cycle, with busy high.
// Results are flagged by done for one cycle only; the receiver cannot stall them.
`default_nettype none
module handle_allocator_with_reuse import hal_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire cmd_t cmd_i,
  output logic      busy,
  output logic      done_o,
  output res_t      result_o
);

  logic   full, clearing, push, pop;
  entry_t entry;
  qhead_t head;

  hal_front u_front (
    .start      (start),
    .cmd_i      (cmd_i),
    .full_i     (full),
    .clearing_i (clearing),
    .busy       (busy),
    .push_o     (push),
    .entry_o    (entry)
  );

  hal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .head_o  (head)
  );

  hal_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire
